@@ rtl/core/gbp_pkg.sv @@
package gbp_pkg;

    // Defaults for the top-level parameters
    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int ADDR_SHIFT_DEF    = 3;
    localparam int MAX_HISTORY_DEF   = 20;

    // Fixed field widths
    localparam int ADDR_W  = 32;
    localparam int IDX_W   = 12;
    localparam int CTR_W   = 2;
    localparam int TSL_W   = 4;
    localparam int HLEN_W  = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE_LOG2 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LENGTH  = 1'b1;

    localparam logic [TSL_W-1:0]  TSL_RST  = 4'd12;
    localparam logic [HLEN_W-1:0] HLEN_RST = 5'd12;

    // Action field codes
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    // Counter limits
    localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;
    localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic             is_update;
        logic             taken;
        logic [IDX_W-1:0] idx;      // masked to the configured table size
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ rtl/core/gshare_branch_predictor.sv @@
// Gshare direction predictor: a global history register and a table of
// TABLE_ENTRIES 2-bit saturating counters. Push an item (action 0 = lookup,
// 1 = update) while full is low; items with is_conditional low are taken and
// dropped. A conditional lookup yields one result (predict_taken, table_index,
// counter_value) on the output queue; an update yields none but shifts the
// outcome into the history and trains the counter at train_index.
// Timing: the front accepts and classifies an item in its accept cycle
// (history and index are formed there) and parks it in a two-entry command
// queue. The back handles one conditional item at a time in steps: pop,
// reciprocal multiply and remainder for the index reduction, registered
// table read, then counter write or result load; it pops no new item until
// it is done. A lookup also holds in its result-load step while the previous
// result is not popped. After reset the table is initialized by a sweep
// of all TABLE_ENTRIES entries, with full held high; configuration writes
// are taken at any time and should be made only while the block is idle.
module gshare_branch_predictor #(
    parameter int TABLE_ENTRIES = gbp_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_SHIFT    = gbp_pkg::ADDR_SHIFT_DEF,
    parameter int MAX_HISTORY   = gbp_pkg::MAX_HISTORY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: index 0 table_size_log2, index 1 history_length
    input  logic                              i_cfg_we,
    input  logic [gbp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gbp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input beat
    input  logic                              push,
    output logic                              full,
    input  logic                              i_action,
    input  logic [gbp_pkg::ADDR_W-1:0]        i_branch_addr,
    input  logic                              i_is_conditional,
    input  logic                              i_outcome_taken,
    input  logic [gbp_pkg::IDX_W-1:0]         i_train_index,
    // result beat
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_predict_taken,
    output logic [gbp_pkg::IDX_W-1:0]         o_table_index,
    output logic [gbp_pkg::CTR_W-1:0]         o_counter_value
);
    import gbp_pkg::*;

    t_cmd    wr_cmd;
    t_cmd    rd_cmd;
    t_q_stat q_stat;
    logic    q_wr;
    logic    q_rd;
    logic    busy;

    // front: config, history, index formation
    gbp_front #(
        .ADDR_SHIFT  (ADDR_SHIFT),
        .MAX_HISTORY (MAX_HISTORY)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_push           (push),
        .i_action         (i_action),
        .i_branch_addr    (i_branch_addr),
        .i_is_conditional (i_is_conditional),
        .i_outcome_taken  (i_outcome_taken),
        .i_train_index    (i_train_index),
        .i_q_stat         (q_stat),
        .i_busy           (busy),
        .o_full           (full),
        .o_wr             (q_wr),
        .o_wr_cmd         (wr_cmd)
    );

    // decoupling queue
    gbp_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_wr),
        .i_wr_cmd (wr_cmd),
        .i_rd     (q_rd),
        .o_rd_cmd (rd_cmd),
        .o_stat   (q_stat)
    );

    // back: index reduction, counter table, result register
    gbp_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_stat        (q_stat),
        .i_rd_cmd        (rd_cmd),
        .o_rd            (q_rd),
        .o_busy          (busy),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_predict_taken (o_predict_taken),
        .o_table_index   (o_table_index),
        .o_counter_value (o_counter_value)
    );

endmodule

@@ rtl/core/gbp_front.sv @@
module gbp_front #(
    parameter int ADDR_SHIFT  = gbp_pkg::ADDR_SHIFT_DEF,
    parameter int MAX_HISTORY = gbp_pkg::MAX_HISTORY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gbp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gbp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_push,
    input  logic                              i_action,
    input  logic [gbp_pkg::ADDR_W-1:0]        i_branch_addr,
    input  logic                              i_is_conditional,
    input  logic                              i_outcome_taken,
    input  logic [gbp_pkg::IDX_W-1:0]         i_train_index,
    input  gbp_pkg::t_q_stat                  i_q_stat,
    input  logic                              i_busy,
    output logic                              o_full,
    output logic                              o_wr,
    output gbp_pkg::t_cmd                     o_wr_cmd
);
    import gbp_pkg::*;

    logic [TSL_W-1:0]       r_tsl;
    logic [HLEN_W-1:0]      r_hlen;
    logic [MAX_HISTORY-1:0] r_hist;
    logic [MAX_HISTORY-1:0] n_hist;

    logic                   accept;
    logic [ADDR_W-1:0]      addr_sh;
    logic [ADDR_W-1:0]      hist_ext;
    logic [IDX_W-1:0]       idx_mask;
    logic [IDX_W-1:0]       raw_idx;
    logic [MAX_HISTORY-1:0] hist_mask;
    logic [MAX_HISTORY:0]   hist_shift;

    always_comb begin
        addr_sh  = i_branch_addr >> ADDR_SHIFT;
        hist_ext = ADDR_W'(r_hist);

        // index bits kept: table_size_log2, capped at IDX_W
        for (int k = 0; k < IDX_W; k++) begin
            idx_mask[k] = (TSL_W'(k) < r_tsl);
        end
        // history bits kept: history_length, capped at MAX_HISTORY
        for (int k = 0; k < MAX_HISTORY; k++) begin
            hist_mask[k] = (6'(k) < {1'b0, r_hlen});
        end

        raw_idx = (i_action == ACT_UPDATE) ? i_train_index
                                           : (addr_sh[IDX_W-1:0] ^ hist_ext[IDX_W-1:0]);

        hist_shift = {r_hist, i_outcome_taken};
        n_hist     = hist_shift[MAX_HISTORY-1:0] & hist_mask;

        o_full = i_q_stat.full || i_busy;
        accept = i_push && !o_full;
        // unconditional items are taken and dropped here
        o_wr   = accept && i_is_conditional;

        o_wr_cmd.is_update = (i_action == ACT_UPDATE);
        o_wr_cmd.taken     = i_outcome_taken;
        o_wr_cmd.idx       = raw_idx & idx_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsl  <= TSL_RST;
            r_hlen <= HLEN_RST;
            r_hist <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TABLE_SIZE_LOG2: r_tsl  <= i_cfg_data[TSL_W-1:0];
                    CFG_HISTORY_LENGTH:  r_hlen <= i_cfg_data[HLEN_W-1:0];
                    default: ;
                endcase
            end
            if (o_wr && (i_action == ACT_UPDATE)) begin
                r_hist <= n_hist;
            end
        end
    end

endmodule

@@ rtl/core/gbp_fifo.sv @@
module gbp_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  gbp_pkg::t_cmd     i_wr_cmd,
    input  logic              i_rd,
    output gbp_pkg::t_cmd     o_rd_cmd,
    output gbp_pkg::t_q_stat  o_stat
);
    import gbp_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_rd_cmd     = r_mem[r_rp];
    assign o_stat.full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_rd) begin
                r_rp <= ptr_inc(r_rp);
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_stat.full))
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && o_stat.empty))
        else $error("command queue read while empty");

endmodule

@@ rtl/core/gbp_back.sv @@
module gbp_back #(
    parameter int TABLE_ENTRIES = gbp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gbp_pkg::t_q_stat              i_q_stat,
    input  gbp_pkg::t_cmd                 i_rd_cmd,
    output logic                          o_rd,
    output logic                          o_busy,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic                          o_predict_taken,
    output logic [gbp_pkg::IDX_W-1:0]     o_table_index,
    output logic [gbp_pkg::CTR_W-1:0]     o_counter_value
);
    import gbp_pkg::*;

    localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int T_W   = $clog2(TABLE_ENTRIES + 1);
    // reciprocal for index % TABLE_ENTRIES; exact for any IDX_W-bit index
    localparam int QS    = IDX_W + $clog2(TABLE_ENTRIES) + 1;
    localparam int M_W   = IDX_W + 3;
    localparam logic [M_W-1:0] RECIP = M_W'(((64'd1 << QS) + 64'(TABLE_ENTRIES) - 64'd1)
                                            / 64'(TABLE_ENTRIES));
    localparam int P1_W  = IDX_W + M_W;
    localparam int P2_W  = IDX_W + T_W;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_QUO,
        ST_REM,
        ST_MEM,
        ST_USE
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_sweep;
    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_quo;
    logic [IDX_W-1:0] r_rem;
    logic [CTR_W-1:0] r_rdata;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_index;
    logic [CTR_W-1:0] r_out_ctr;

    logic [CTR_W-1:0] r_mem [TABLE_ENTRIES];

    logic [P1_W-1:0]     prod_q;
    logic [P2_W-1:0]     prod_r;
    logic [AW+IDX_W-1:0] addr_pad;
    logic [AW-1:0]       mem_addr;
    logic [AW-1:0]       wr_addr;
    logic [CTR_W-1:0]    wr_data;
    logic                wr_en;
    logic [CTR_W-1:0]    ctr_next;
    logic                out_load;

    always_comb begin
        prod_q   = P1_W'(r_cmd.idx) * P1_W'(RECIP);
        prod_r   = P2_W'(r_quo) * P2_W'(TABLE_ENTRIES);
        addr_pad = {{AW{1'b0}}, r_rem};
        mem_addr = addr_pad[AW-1:0];

        if (r_cmd.taken) begin
            ctr_next = (r_rdata == CTR_MAX) ? CTR_MAX : r_rdata + 1'b1;
        end else begin
            ctr_next = (r_rdata == CTR_MIN) ? CTR_MIN : r_rdata - 1'b1;
        end

        out_load = (r_state == ST_USE) && !r_cmd.is_update && (!r_out_valid || i_pop);
        wr_en    = (r_state == ST_SWEEP) || ((r_state == ST_USE) && r_cmd.is_update);
        wr_addr  = (r_state == ST_SWEEP) ? r_sweep : mem_addr;
        // reset pattern: even entries 1, odd entries 2
        wr_data  = (r_state == ST_SWEEP) ? {r_sweep[0], ~r_sweep[0]} : ctr_next;

        o_rd    = (r_state == ST_IDLE) && !i_q_stat.empty;
        o_busy  = (r_state == ST_SWEEP);
        o_empty = !r_out_valid;
        o_predict_taken = r_out_ctr[CTR_W-1];
        o_table_index   = r_out_index;
        o_counter_value = r_out_ctr;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_index <= r_rem;
                r_out_ctr   <= r_rdata;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == AW'(TABLE_ENTRIES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (o_rd) begin
                        r_cmd   <= i_rd_cmd;
                        r_state <= ST_QUO;
                    end
                end
                ST_QUO: begin
                    r_quo   <= IDX_W'(prod_q >> QS);
                    r_state <= ST_REM;
                end
                ST_REM: begin
                    r_rem   <= r_cmd.idx - prod_r[IDX_W-1:0];
                    r_state <= ST_MEM;
                end
                ST_MEM: begin
                    r_state <= ST_USE;
                end
                ST_USE: begin
                    if (r_cmd.is_update || out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MEM) |-> (32'(mem_addr) < 32'(TABLE_ENTRIES)))
        else $error("reduced table index out of range");

    a_lookup_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_USE && !r_cmd.is_update && r_out_valid && !i_pop)
        |=> (r_state == ST_USE))
        else $error("lookup left while result slot occupied");

    a_load_from_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_USE && !$past(r_cmd.is_update)))
        else $error("result produced outside lookup completion");

endmodule
